// ===== design/hbridge_pwm_soft_start_ramp_core_assert.svh =====
// ----------------------------------------------------------------------------
// H-bridge soft-start ramp: assertion macros
// Shorthand for clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef HBRIDGE_PWM_SOFT_START_RAMP_CORE_ASSERT_SVH
`define HBRIDGE_PWM_SOFT_START_RAMP_CORE_ASSERT_SVH

// same-cycle implication
`define HPSSR_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HPSSR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/hpssr_pkg.sv =====
// ----------------------------------------------------------------------------
// H-bridge soft-start ramp: shared package
// Widths, operation and direction codes, register indexes, ramp helper.
// ----------------------------------------------------------------------------
package hpssr_pkg;

   localparam int DUTY_W = 7;
   localparam int OP_W   = 2;
   localparam int DIR_W  = 2;
   localparam int IDX_W  = 3;
   localparam int WR_W   = 8;
   localparam int MS_W   = 2;

   localparam logic [DUTY_W-1:0] MID_DUTY     = 7'd50;
   localparam logic [DUTY_W-1:0] FULL_DUTY    = 7'd100;
   localparam logic [WR_W-1:0]   NONE_WRITTEN = 8'hFF;

   localparam logic [OP_W-1:0] OP_POST  = 2'd0;
   localparam logic [OP_W-1:0] OP_TICK  = 2'd1;
   localparam logic [OP_W-1:0] OP_ESTOP = 2'd2;

   localparam logic [DIR_W-1:0] DIR_STOP    = 2'd0;
   localparam logic [DIR_W-1:0] DIR_FWD     = 2'd1;
   localparam logic [DIR_W-1:0] DIR_REV     = 2'd2;
   localparam logic [DIR_W-1:0] DIR_REV_ALT = 2'd3;

   localparam logic [IDX_W-1:0] REG_DEFAULT_DUTY = 3'd0;
   localparam logic [IDX_W-1:0] REG_DUTY_MIN     = 3'd1;
   localparam logic [IDX_W-1:0] REG_DUTY_MAX     = 3'd2;
   localparam logic [IDX_W-1:0] REG_RUN_STEP     = 3'd3;
   localparam logic [IDX_W-1:0] REG_STOP_STEP    = 3'd4;

   localparam logic [MS_W-1:0] MS_STOPPED = 2'd0;
   localparam logic [MS_W-1:0] MS_RAMPING = 2'd1;
   localparam logic [MS_W-1:0] MS_RUNNING = 2'd2;

   typedef enum logic [2:0] {
      ST_STOPPED = 3'b001,
      ST_RAMPING = 3'b010,
      ST_RUNNING = 3'b100
   } ctrl_state_type;

   // move cur toward tgt by step, never overshooting
   function automatic logic [DUTY_W-1:0] step_toward(input logic [DUTY_W-1:0] cur,
                                                     input logic [DUTY_W-1:0] tgt,
                                                     input logic [DUTY_W-1:0] step);
      logic [DUTY_W:0] up_sum;
      logic [DUTY_W:0] lim;
      logic [DUTY_W-1:0] res;
      up_sum = {1'b0, cur} + {1'b0, step};
      lim    = {1'b0, tgt} + {1'b0, step};
      res    = cur;
      if (cur < tgt) begin
         res = (up_sum > {1'b0, tgt}) ? tgt : up_sum[DUTY_W-1:0];
      end else if (cur > tgt) begin
         res = ({1'b0, cur} > lim) ? (cur - step) : tgt;
      end
      return res;
   endfunction

endpackage

// ===== design/hpssr_intf.sv =====
// ----------------------------------------------------------------------------
// H-bridge soft-start ramp: channel interfaces
// Command, result and register-write channels with valid/ready.
// ----------------------------------------------------------------------------
interface hpssr_req_intf;
   logic                         valid;
   logic                         ready;
   logic [hpssr_pkg::OP_W-1:0]   operation;
   logic [hpssr_pkg::DIR_W-1:0]  direction;
   logic [hpssr_pkg::DUTY_W-1:0] cmd_duty;

   modport source (output valid, operation, direction, cmd_duty, input ready);
   modport sink   (input valid, operation, direction, cmd_duty, output ready);
endinterface

interface hpssr_rsp_intf;
   logic                         valid;
   logic                         ready;
   logic [hpssr_pkg::DUTY_W-1:0] u_duty;
   logic [hpssr_pkg::DUTY_W-1:0] v_duty;
   logic                         u_update;
   logic                         v_update;
   logic                         run_polarity;
   logic [hpssr_pkg::MS_W-1:0]   motor_state;
   logic [hpssr_pkg::DIR_W-1:0]  active_direction;

   modport source (output valid, u_duty, v_duty, u_update, v_update, run_polarity,
                   motor_state, active_direction, input ready);
   modport sink   (input valid, u_duty, v_duty, u_update, v_update, run_polarity,
                   motor_state, active_direction, output ready);
endinterface

interface hpssr_csr_intf;
   logic                         valid;
   logic                         ready;
   logic [hpssr_pkg::IDX_W-1:0]  index;
   logic [hpssr_pkg::DUTY_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/hbridge_pwm_soft_start_ramp_core.sv =====
// ----------------------------------------------------------------------------
// H-bridge PWM soft-start ramp core
// Posts commands, steps U/V duties toward targets on ticks, emergency stop.
// ----------------------------------------------------------------------------
// Takes one word per clock and returns one result word per input word in the
// cycle after acceptance. All the work is a single pass of compare/add logic
// from the state registers into the result register, so the sustained rate
// is one word per cycle; the input stalls only while the result register
// holds a word the consumer has not yet taken. Register writes are accepted
// every cycle outside reset and should only be issued while the core is idle.
module hbridge_pwm_soft_start_ramp_core (
   input  logic         clock,
   input  logic         reset,
   hpssr_req_intf.sink   req_ch,
   hpssr_rsp_intf.source rsp_ch,
   hpssr_csr_intf.sink   csr_ch
);
   import hpssr_pkg::*;

   // configuration
   logic [DUTY_W-1:0] default_duty_ff, duty_min_ff, duty_max_ff, run_step_ff, stop_step_ff;

   // control state
   logic [DIR_W-1:0]  pend_dir_ff, pend_dir_in;
   logic [DUTY_W-1:0] pend_duty_ff, pend_duty_in;
   ctrl_state_type    state_ff, state_in;
   logic [DIR_W-1:0]  run_dir_ff, run_dir_in;
   logic [DUTY_W-1:0] u_cur_ff, u_cur_in, v_cur_ff, v_cur_in;
   logic [WR_W-1:0]   u_wr_ff, u_wr_in, v_wr_ff, v_wr_in;

   // result register
   logic              rsp_valid_ff;
   logic [DUTY_W-1:0] rsp_u_duty_ff, rsp_v_duty_ff;
   logic              rsp_u_upd_ff, rsp_v_upd_ff, rsp_pol_ff;
   logic [MS_W-1:0]   rsp_ms_ff, ms_in;
   logic [DIR_W-1:0]  rsp_dir_ff;
   logic              u_upd_in, v_upd_in;

   logic              req_take, csr_take;

   // tick datapath
   logic [DUTY_W-1:0] eff_raw, eff_lo, eff_hi, eff;
   logic [DUTY_W-1:0] u_tgt, v_tgt, step_sel;
   logic [DUTY_W-1:0] u_base, v_base, u_step, v_step;
   logic [WR_W-1:0]   u_wr_base, v_wr_base;
   logic              from_stop;

   assign req_ch.ready = !reset && (!rsp_valid_ff || rsp_ch.ready);
   assign csr_ch.ready = !reset;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign csr_take     = csr_ch.valid && csr_ch.ready;

   always_comb begin
      eff_raw = (pend_duty_ff == '0) ? default_duty_ff : pend_duty_ff;
      eff_lo  = (eff_raw < duty_min_ff) ? duty_min_ff : eff_raw;
      eff_hi  = (eff_lo > duty_max_ff) ? duty_max_ff : eff_lo;
      eff     = (eff_hi > FULL_DUTY) ? FULL_DUTY : eff_hi;

      case (pend_dir_ff)
         DIR_STOP: begin
            u_tgt = MID_DUTY;
            v_tgt = MID_DUTY;
         end
         DIR_FWD: begin
            v_tgt = eff;
            u_tgt = FULL_DUTY - eff;
         end
         default: begin
            u_tgt = eff;
            v_tgt = FULL_DUTY - eff;
         end
      endcase

      // leaving stopped restarts the ramp from 50/50 with nothing written
      from_stop = (state_ff == ST_STOPPED);
      u_base    = from_stop ? MID_DUTY : u_cur_ff;
      v_base    = from_stop ? MID_DUTY : v_cur_ff;
      u_wr_base = from_stop ? NONE_WRITTEN : u_wr_ff;
      v_wr_base = from_stop ? NONE_WRITTEN : v_wr_ff;
      step_sel  = (pend_dir_ff == DIR_STOP) ? stop_step_ff : run_step_ff;
      u_step    = step_toward(u_base, u_tgt, step_sel);
      v_step    = step_toward(v_base, v_tgt, step_sel);
   end

   always_comb begin
      pend_dir_in  = pend_dir_ff;
      pend_duty_in = pend_duty_ff;
      state_in     = state_ff;
      run_dir_in   = run_dir_ff;
      u_cur_in     = u_cur_ff;
      v_cur_in     = v_cur_ff;
      u_wr_in      = u_wr_ff;
      v_wr_in      = v_wr_ff;
      u_upd_in     = 1'b0;
      v_upd_in     = 1'b0;

      case (req_ch.operation)
         OP_POST: begin
            pend_dir_in  = (req_ch.direction == DIR_REV_ALT) ? DIR_REV : req_ch.direction;
            pend_duty_in = req_ch.cmd_duty;
         end
         OP_TICK: begin
            if (!(from_stop && pend_dir_ff == DIR_STOP)) begin
               u_cur_in = u_step;
               v_cur_in = v_step;
               u_upd_in = (u_wr_base != {1'b0, u_step});
               v_upd_in = (v_wr_base != {1'b0, v_step});
               u_wr_in  = {1'b0, u_step};
               v_wr_in  = {1'b0, v_step};
               if (pend_dir_ff != DIR_STOP) begin
                  run_dir_in = pend_dir_ff;
               end
               if (u_step == u_tgt && v_step == v_tgt) begin
                  state_in = (pend_dir_ff == DIR_STOP) ? ST_STOPPED : ST_RUNNING;
               end else begin
                  state_in = ST_RAMPING;
               end
            end
         end
         OP_ESTOP: begin
            pend_dir_in  = DIR_STOP;
            pend_duty_in = '0;
            u_cur_in     = MID_DUTY;
            v_cur_in     = MID_DUTY;
            u_wr_in      = {1'b0, MID_DUTY};
            v_wr_in      = {1'b0, MID_DUTY};
            state_in     = ST_STOPPED;
            u_upd_in     = 1'b1;
            v_upd_in     = 1'b1;
         end
         default: ;
      endcase

      case (state_in)
         ST_STOPPED: ms_in = MS_STOPPED;
         ST_RAMPING: ms_in = MS_RAMPING;
         ST_RUNNING: ms_in = MS_RUNNING;
         default:    ms_in = MS_STOPPED;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         default_duty_ff <= 7'd80;
         duty_min_ff     <= 7'd10;
         duty_max_ff     <= 7'd90;
         run_step_ff     <= 7'd2;
         stop_step_ff    <= 7'd5;
      end else if (csr_take) begin
         case (csr_ch.index)
            REG_DEFAULT_DUTY: default_duty_ff <= csr_ch.data;
            REG_DUTY_MIN:     duty_min_ff     <= csr_ch.data;
            REG_DUTY_MAX:     duty_max_ff     <= csr_ch.data;
            REG_RUN_STEP:     run_step_ff     <= csr_ch.data;
            REG_STOP_STEP:    stop_step_ff    <= csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_dir_ff  <= DIR_STOP;
         pend_duty_ff <= '0;
         state_ff     <= ST_STOPPED;
         run_dir_ff   <= DIR_STOP;
         u_cur_ff     <= MID_DUTY;
         v_cur_ff     <= MID_DUTY;
         u_wr_ff      <= NONE_WRITTEN;
         v_wr_ff      <= NONE_WRITTEN;
      end else if (req_take) begin
         pend_dir_ff  <= pend_dir_in;
         pend_duty_ff <= pend_duty_in;
         state_ff     <= state_in;
         run_dir_ff   <= run_dir_in;
         u_cur_ff     <= u_cur_in;
         v_cur_ff     <= v_cur_in;
         u_wr_ff      <= u_wr_in;
         v_wr_ff      <= v_wr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_u_duty_ff <= u_cur_in;
         rsp_v_duty_ff <= v_cur_in;
         rsp_u_upd_ff  <= u_upd_in;
         rsp_v_upd_ff  <= v_upd_in;
         rsp_pol_ff    <= (state_in != ST_STOPPED);
         rsp_ms_ff     <= ms_in;
         rsp_dir_ff    <= run_dir_in;
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.u_duty           = rsp_u_duty_ff;
   assign rsp_ch.v_duty           = rsp_v_duty_ff;
   assign rsp_ch.u_update         = rsp_u_upd_ff;
   assign rsp_ch.v_update         = rsp_v_upd_ff;
   assign rsp_ch.run_polarity     = rsp_pol_ff;
   assign rsp_ch.motor_state      = rsp_ms_ff;
   assign rsp_ch.active_direction = rsp_dir_ff;

endmodule

// ===== design/hpssr_checker.sv =====
// ----------------------------------------------------------------------------
// H-bridge soft-start ramp: port checker
// Watches the core's channels and checks result behaviour over time.
// ----------------------------------------------------------------------------
`include "hbridge_pwm_soft_start_ramp_core_assert.svh"

module hpssr_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic [hpssr_pkg::OP_W-1:0]   req_operation,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [hpssr_pkg::DUTY_W-1:0] rsp_u_duty,
   input logic [hpssr_pkg::DUTY_W-1:0] rsp_v_duty,
   input logic                         rsp_u_update,
   input logic                         rsp_v_update,
   input logic                         rsp_run_polarity,
   input logic [hpssr_pkg::MS_W-1:0]   rsp_motor_state
);
   import hpssr_pkg::*;

   logic req_take;
   assign req_take = req_valid && req_ready;

   // a result word stays up until taken
   `HPSSR_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "result word dropped while stalled")

   // polarity follows the control state
   `HPSSR_ASSERT_NOW(a_polarity, clock, reset, rsp_valid, rsp_run_polarity == (rsp_motor_state != MS_STOPPED), "run polarity disagrees with motor state")

   // emergency stop lands at 50/50, stopped, both compares rewritten
   `HPSSR_ASSERT_NXT(a_estop, clock, reset, req_take && req_operation == OP_ESTOP, rsp_valid && rsp_u_duty == MID_DUTY && rsp_v_duty == MID_DUTY && rsp_u_update && rsp_v_update && rsp_motor_state == MS_STOPPED, "emergency stop result wrong")

   // posting a command never rewrites a compare
   `HPSSR_ASSERT_NXT(a_post_quiet, clock, reset, req_take && req_operation == OP_POST, rsp_valid && !rsp_u_update && !rsp_v_update, "post command flagged an update")

endmodule

bind hbridge_pwm_soft_start_ramp_core hpssr_checker u_hpssr_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .req_operation    (req_ch.operation),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_u_duty       (rsp_ch.u_duty),
   .rsp_v_duty       (rsp_ch.v_duty),
   .rsp_u_update     (rsp_ch.u_update),
   .rsp_v_update     (rsp_ch.v_update),
   .rsp_run_polarity (rsp_ch.run_polarity),
   .rsp_motor_state  (rsp_ch.motor_state)
);

// ===== tb/sv/hbridge_pwm_soft_start_ramp_core_test.sv =====
// ----------------------------------------------------------------------------
// H-bridge soft-start ramp core: self-checking testbench
// Runs a table of directed command/tick/e-stop words, then random command
// sequences followed by tick trains under several register settings. Every
// result word is checked field by field against an in-bench duty predictor or a fixed table word.
// ----------------------------------------------------------------------------
module hbridge_pwm_soft_start_ramp_core_test;
   import hpssr_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int IDLE_PCT = 12;
   localparam int N_DIRECTED = 24;

   typedef struct packed {
      logic [DUTY_W-1:0] u_duty;
      logic [DUTY_W-1:0] v_duty;
      logic              u_update;
      logic              v_update;
      logic              run_polarity;
      logic [MS_W-1:0]   motor_state;
      logic [DIR_W-1:0]  active_direction;
   } duty_word_type;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [DIR_W-1:0]  dir;
      logic [DUTY_W-1:0] duty;
      bit                typed;
      duty_word_type     want;
   } stim_row_type;

   localparam duty_word_type AT_REST =
      '{MID_DUTY, MID_DUTY, 1'b0, 1'b0, 1'b0, MS_STOPPED, DIR_STOP};

   logic clock = 1'b0;
   logic reset;

   hpssr_req_intf req_if();
   hpssr_rsp_intf rsp_if();
   hpssr_csr_intf csr_if();

   hbridge_pwm_soft_start_ramp_core uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   // predictor copy of registers and state
   logic [DUTY_W-1:0] cfg_default_duty, cfg_duty_min, cfg_duty_max;
   logic [DUTY_W-1:0] cfg_run_step, cfg_stop_step;
   logic [DIR_W-1:0]  pend_dir, run_dir;
   logic [DUTY_W-1:0] pend_duty, u_now, v_now;
   logic [MS_W-1:0]   drive_state;
   logic [WR_W-1:0]   u_wr, v_wr;

   duty_word_type words_due[$];
   int            fail_count = 0;
   bit            no_idle = 1'b0;
   stim_row_type  directed_rows [0:N_DIRECTED-1];

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int ramp_toward(input int cur, input int tgt, input int stp);
      if (cur < tgt) return (cur + stp > tgt) ? tgt : cur + stp;
      if (cur > tgt) return (cur > tgt + stp) ? cur - stp : tgt;
      return cur;
   endfunction

   function automatic duty_word_type predict_word(input logic [OP_W-1:0] op,
                                                  input logic [DIR_W-1:0] dir,
                                                  input logic [DUTY_W-1:0] duty);
      duty_word_type w;
      int eff, ut, vt, stp;
      logic uu, vu;
      uu = 1'b0;
      vu = 1'b0;
      case (op)
         OP_POST: begin
            pend_dir  = (dir == DIR_REV_ALT) ? DIR_REV : dir;
            pend_duty = duty;
         end
         OP_TICK: begin
            if (pend_dir == DIR_STOP) begin
               ut = MID_DUTY;
               vt = MID_DUTY;
            end else begin
               eff = (pend_duty == 0) ? cfg_default_duty : pend_duty;
               if (eff < cfg_duty_min) eff = cfg_duty_min;
               if (eff > cfg_duty_max) eff = cfg_duty_max;
               if (eff > FULL_DUTY) eff = FULL_DUTY;
               if (pend_dir == DIR_FWD) begin
                  vt = eff;
                  ut = FULL_DUTY - eff;
               end else begin
                  ut = eff;
                  vt = FULL_DUTY - eff;
               end
            end
            // a stop command while stopped leaves everything alone
            if (!(drive_state == MS_STOPPED && pend_dir == DIR_STOP)) begin
               if (drive_state == MS_STOPPED) begin
                  run_dir = pend_dir;
                  u_now   = MID_DUTY;
                  v_now   = MID_DUTY;
                  u_wr    = NONE_WRITTEN;
                  v_wr    = NONE_WRITTEN;
               end
               stp   = (pend_dir == DIR_STOP) ? cfg_stop_step : cfg_run_step;
               u_now = DUTY_W'(ramp_toward(u_now, ut, stp));
               v_now = DUTY_W'(ramp_toward(v_now, vt, stp));
               uu    = (u_wr != {1'b0, u_now});
               vu    = (v_wr != {1'b0, v_now});
               u_wr  = {1'b0, u_now};
               v_wr  = {1'b0, v_now};
               if (u_now == ut && v_now == vt) begin
                  drive_state = (pend_dir == DIR_STOP) ? MS_STOPPED : MS_RUNNING;
               end else begin
                  drive_state = MS_RAMPING;
               end
               if (pend_dir != DIR_STOP) run_dir = pend_dir;
            end
         end
         OP_ESTOP: begin
            pend_dir    = DIR_STOP;
            pend_duty   = '0;
            u_now       = MID_DUTY;
            v_now       = MID_DUTY;
            u_wr        = {1'b0, MID_DUTY};
            v_wr        = {1'b0, MID_DUTY};
            drive_state = MS_STOPPED;
            uu          = 1'b1;
            vu          = 1'b1;
         end
         default: ;
      endcase
      w.u_duty           = u_now;
      w.v_duty           = v_now;
      w.u_update         = uu;
      w.v_update         = vu;
      w.run_polarity     = (drive_state != MS_STOPPED);
      w.motor_state      = drive_state;
      w.active_direction = run_dir;
      return w;
   endfunction

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_word(input logic [OP_W-1:0] op, input logic [DIR_W-1:0] dir,
                            input logic [DUTY_W-1:0] duty, input bit typed,
                            input duty_word_type want);
      duty_word_type w;
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.operation <= op;
      req_if.direction <= dir;
      req_if.cmd_duty  <= duty;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      w = predict_word(op, dir, duty);
      words_due.push_back(typed ? want : w);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [IDX_W-1:0] idx, input logic [DUTY_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      case (idx)
         REG_DEFAULT_DUTY: cfg_default_duty = data;
         REG_DUTY_MIN:     cfg_duty_min     = data;
         REG_DUTY_MAX:     cfg_duty_max     = data;
         REG_RUN_STEP:     cfg_run_step     = data;
         REG_STOP_STEP:    cfg_stop_step    = data;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      while (words_due.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // mostly a command followed by a tick train; e-stops and unused codes as noise
   task automatic run_phase(input int quota);
      int done, pick, ticks;
      logic [DUTY_W-1:0] d;
      done = 0;
      while (done < quota) begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            send_word(OP_UNUSED, DIR_W'($urandom_range(3)), DUTY_W'($urandom_range(127)),
                      1'b0, '0);
         end else if (pick < 10) begin
            send_word(OP_ESTOP, DIR_W'($urandom_range(3)), DUTY_W'($urandom_range(127)),
                      1'b0, '0);
            done++;
         end else begin
            pick = $urandom_range(99);
            d = (pick < 20) ? '0 :
                (pick < 35) ? DUTY_W'($urandom_range(127)) : DUTY_W'($urandom_range(100));
            send_word(OP_POST, DIR_W'($urandom_range(3)), d, 1'b0, '0);
            done++;
            ticks = ($urandom_range(3) == 0) ? $urandom_range(1, 5) : $urandom_range(5, 60);
            repeat (ticks) begin
               send_word(OP_TICK, DIR_W'($urandom_range(3)), DUTY_W'($urandom_range(127)),
                         1'b0, '0);
               done++;
            end
         end
      end
   endtask

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   always @(negedge clock) begin
      rsp_if.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      duty_word_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (words_due.size() == 0) begin
            $error("result word with nothing expected");
            fail_count++;
         end else begin
            want = words_due.pop_front();
            check_field("u_duty", want.u_duty, rsp_if.u_duty);
            check_field("v_duty", want.v_duty, rsp_if.v_duty);
            check_field("u_update", want.u_update, rsp_if.u_update);
            check_field("v_update", want.v_update, rsp_if.v_update);
            check_field("run_polarity", want.run_polarity, rsp_if.run_polarity);
            check_field("motor_state", want.motor_state, rsp_if.motor_state);
            check_field("active_direction", want.active_direction,
                        rsp_if.active_direction);
         end
      end
   end

   initial begin
      int i, phase, quota;
      logic [DUTY_W-1:0] vals [5];

      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.operation = OP_POST;
      req_if.direction = DIR_STOP;
      req_if.cmd_duty  = '0;
      rsp_if.ready     = 1'b0;
      csr_if.valid     = 1'b0;
      csr_if.index     = REG_DEFAULT_DUTY;
      csr_if.data      = '0;

      cfg_default_duty = 7'd80;
      cfg_duty_min     = 7'd10;
      cfg_duty_max     = 7'd90;
      cfg_run_step     = 7'd2;
      cfg_stop_step    = 7'd5;
      pend_dir         = DIR_STOP;
      pend_duty        = '0;
      drive_state      = MS_STOPPED;
      run_dir          = DIR_STOP;
      u_now            = MID_DUTY;
      v_now            = MID_DUTY;
      u_wr             = NONE_WRITTEN;
      v_wr             = NONE_WRITTEN;

      directed_rows = '{
         '{OP_TICK,   DIR_STOP,    7'd0,   1'b1, AT_REST},
         '{OP_UNUSED, DIR_REV_ALT, 7'd127, 1'b1, AT_REST},
         '{OP_POST,   DIR_STOP,    7'd127, 1'b1, AT_REST},
         '{OP_TICK,   DIR_STOP,    7'd0,   1'b1, AT_REST},
         '{OP_POST,   DIR_FWD,     7'd0,   1'b1, AT_REST},
         '{OP_TICK,   DIR_STOP,    7'd0,   1'b0, '0},
         '{OP_TICK,   DIR_STOP,    7'd0,   1'b0, '0},
         '{OP_TICK,   DIR_STOP,    7'd0,   1'b0, '0},
         '{OP_ESTOP,  DIR_REV_ALT, 7'd127, 1'b1,
           '{MID_DUTY, MID_DUTY, 1'b1, 1'b1, 1'b0, MS_STOPPED, DIR_FWD}},
         '{OP_POST,   DIR_REV_ALT, 7'd127, 1'b1,
           '{MID_DUTY, MID_DUTY, 1'b0, 1'b0, 1'b0, MS_STOPPED, DIR_FWD}},
         '{OP_TICK,   DIR_STOP,    7'd0,   1'b0, '0},
         '{OP_TICK,   DIR_STOP,    7'd0,   1'b0, '0},
         '{OP_POST,   DIR_STOP,    7'd0,   1'b0, '0},
         '{OP_TICK,   DIR_STOP,    7'd0,   1'b0, '0},
         '{OP_TICK,   DIR_STOP,    7'd0,   1'b0, '0},
         '{OP_POST,   DIR_FWD,     7'd1,   1'b0, '0},
         '{OP_TICK,   DIR_STOP,    7'd0,   1'b0, '0},
         '{OP_POST,   DIR_FWD,     7'd100, 1'b0, '0},
         '{OP_TICK,   DIR_STOP,    7'd0,   1'b0, '0},
         '{OP_POST,   DIR_REV,     7'd64,  1'b0, '0},
         '{OP_TICK,   DIR_STOP,    7'd0,   1'b0, '0},
         '{OP_ESTOP,  DIR_STOP,    7'd0,   1'b1,
           '{MID_DUTY, MID_DUTY, 1'b1, 1'b1, 1'b0, MS_STOPPED, DIR_REV}},
         '{OP_ESTOP,  DIR_FWD,     7'd1,   1'b1,
           '{MID_DUTY, MID_DUTY, 1'b1, 1'b1, 1'b0, MS_STOPPED, DIR_REV}},
         '{OP_TICK,   DIR_STOP,    7'd0,   1'b1,
           '{MID_DUTY, MID_DUTY, 1'b0, 1'b0, 1'b0, MS_STOPPED, DIR_REV}}
      };

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < N_DIRECTED; i++) begin
         send_word(directed_rows[i].op, directed_rows[i].dir, directed_rows[i].duty,
                   directed_rows[i].typed, directed_rows[i].want);
      end
      run_phase(350);

      for (phase = 1; phase <= 5; phase++) begin
         drain_results();
         case (phase)
            1: begin
               vals  = '{7'd100, 7'd0, 7'd100, 7'd100, 7'd100};
               quota = 300;
            end
            2: begin
               // min above max: max wins; slowest ramps
               vals  = '{7'd1, 7'd100, 7'd0, 7'd1, 7'd1};
               quota = 350;
            end
            4: begin
               // zero default and run step, max beyond full scale
               vals  = '{7'd0, 7'd0, 7'd127, 7'd0, 7'd7};
               quota = 150;
            end
            default: begin
               vals[0] = DUTY_W'($urandom_range(1, 100));
               vals[1] = DUTY_W'($urandom_range(0, 60));
               vals[2] = DUTY_W'($urandom_range(40, 100));
               vals[3] = DUTY_W'($urandom_range(1, 12));
               vals[4] = DUTY_W'($urandom_range(1, 12));
               quota   = 300;
            end
         endcase
         csr_write(REG_DEFAULT_DUTY, vals[0]);
         csr_write(REG_DUTY_MIN, vals[1]);
         csr_write(REG_DUTY_MAX, vals[2]);
         csr_write(REG_RUN_STEP, vals[3]);
         csr_write(REG_STOP_STEP, vals[4]);
         csr_if.valid <= 1'b0;
         no_idle = (phase == 3);
         run_phase(quota);
      end
      drain_results();

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
